// ===== sv/pia_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pia_pkg
// Types, constants and helpers shared by the priority interrupt acceptor.
// -----------------------------------------------------------------------------
package pia_pkg;

	localparam int NumVectors = 16;
	localparam int IrqW       = $clog2(NumVectors);
	localparam int WordW      = 16;
	localparam int AddrW      = 4;
	localparam int DataW      = 32;

	// status word bits
	localparam int GieBit   = 3;
	localparam int Scg0Bit  = 6;
	localparam int LpmLo    = 4;
	localparam int LpmHi    = 7;

	// vectors 14 and 15 cannot be masked
	localparam logic [NumVectors-1:0] NmiMask = NumVectors'(16'hC000);
	localparam logic [IrqW-1:0]       NmiFirst = IrqW'(14);

	localparam logic [WordW-1:0] VectorBaseRst = 16'hFFE0;
	localparam logic [WordW-1:0] SingleSrcRst  = 16'h034C;
	localparam logic [IrqW-1:0]  WatchdogRst   = IrqW'(10);

	typedef enum logic [1:0] {
		REG_VECTOR_BASE = 2'd0,
		REG_SINGLE_SRC  = 2'd1,
		REG_WATCHDOG    = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef enum logic {
		CMD_RAISE   = 1'b0,
		CMD_SERVICE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic              taken;
		logic [IrqW-1:0]   served_irq;
		logic [WordW-1:0]  vector_address;
		logic [WordW-1:0]  new_stack_pointer;
		logic [WordW-1:0]  saved_pc;
		logic [WordW-1:0]  saved_status;
		logic [WordW-1:0]  new_status;
		logic              left_low_power;
		logic              clear_source_flag;
		logic              masked_warning;
		logic [WordW-1:0]  pending_after;
	} result_t;

	// highest set bit of the pending vector
	function automatic logic [IrqW-1:0] highest_set(input logic [NumVectors-1:0] vec);
		logic [IrqW-1:0] idx;
		idx = '0;
		for (int i = 0; i < NumVectors; i++) begin
			if (vec[i]) begin
				idx = IrqW'(i);
			end
		end
		return idx;
	endfunction

endpackage : pia_pkg
`default_nettype wire

// ===== sv/priority_interrupt_acceptor_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one beat per cycle while the output is not stalled and the skid
//   entry is empty; a skid stage behind the result register keeps the input
//   open for one more beat while the output is stalled.
// Reset (arst_n low, async): pending register cleared, config registers back
//   to base 0xFFE0, single-source 0x034C, watchdog vector 10; no beats in flight.
// -----------------------------------------------------------------------------
// priority_interrupt_acceptor_core
// Fixed-priority 16-vector interrupt acceptor. Raise beats latch a pending
// bit; service beats take the highest pending vector and report the entry
// sequence values (vector address, stack frame, new status, flag clear).
// -----------------------------------------------------------------------------
module priority_interrupt_acceptor_core
	import pia_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,

	// APB-style config port
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [AddrW-1:0]  paddr,
	input  wire logic [DataW-1:0]  pwdata,
	output logic      [DataW-1:0]  prdata,
	output logic                   pready,

	// input channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              command,
	input  wire logic [IrqW-1:0]   irq_number,
	input  wire logic [WordW-1:0]  status_word,
	input  wire logic [WordW-1:0]  stack_pointer,
	input  wire logic [WordW-1:0]  resume_pc,
	input  wire logic              watchdog_interval_mode,

	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic                   taken,
	output logic      [IrqW-1:0]   served_irq,
	output logic      [WordW-1:0]  vector_address,
	output logic      [WordW-1:0]  new_stack_pointer,
	output logic      [WordW-1:0]  saved_pc,
	output logic      [WordW-1:0]  saved_status,
	output logic      [WordW-1:0]  new_status,
	output logic                   left_low_power,
	output logic                   clear_source_flag,
	output logic                   masked_warning,
	output logic      [WordW-1:0]  pending_after
);

	// ---------------------------------------------------------------------
	// Config registers. Register i sits at byte address 4*i; the low two
	// address bits are ignored.
	// ---------------------------------------------------------------------
	logic [WordW-1:0]      vector_base_q;
	logic [NumVectors-1:0] single_src_q;
	logic [IrqW-1:0]       watchdog_q;
	reg_idx_t              reg_sel;
	logic                  cfg_wr;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[AddrW-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_base_q <= VectorBaseRst;
			single_src_q  <= SingleSrcRst;
			watchdog_q    <= WatchdogRst;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_VECTOR_BASE: vector_base_q <= pwdata[WordW-1:0];
				REG_SINGLE_SRC:  single_src_q  <= pwdata[NumVectors-1:0];
				REG_WATCHDOG:    watchdog_q    <= pwdata[IrqW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_VECTOR_BASE: prdata = DataW'(vector_base_q);
			REG_SINGLE_SRC:  prdata = DataW'(single_src_q);
			REG_WATCHDOG:    prdata = DataW'(watchdog_q);
			default:         prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------------
	// Handshake: output register plus one skid entry. Input is stalled only
	// while the skid entry is occupied.
	// ---------------------------------------------------------------------
	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    in_acc;
	logic    out_free;

	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	// ---------------------------------------------------------------------
	// Accept logic: all of it is combinational off the pending register and
	// the incoming beat.
	// ---------------------------------------------------------------------
	logic [NumVectors-1:0] pending_q;
	logic [NumVectors-1:0] pending_nxt;
	logic [IrqW-1:0]       top_irq;
	logic                  gie;
	logic                  do_take;
	logic                  clr_flag;
	result_t               res;

	assign gie     = status_word[GieBit];
	assign top_irq = highest_set(pending_q);
	assign do_take = (command == CMD_SERVICE) && (pending_q != '0)
		&& (gie || ((pending_q & NmiMask) != '0));
	assign clr_flag = (top_irq == watchdog_q) ? watchdog_interval_mode
		: single_src_q[top_irq];

	always_comb begin
		res         = '0;
		pending_nxt = pending_q;
		if (command == CMD_RAISE) begin
			res.masked_warning = !gie && (irq_number < NmiFirst);
			pending_nxt[irq_number] = 1'b1;
		end else if (do_take) begin
			res.taken             = 1'b1;
			res.served_irq        = top_irq;
			// base + 2*n, wraps at 16 bits
			res.vector_address    = vector_base_q
				+ {{(WordW-IrqW-1){1'b0}}, top_irq, 1'b0};
			res.new_stack_pointer = stack_pointer - WordW'(4);
			res.saved_pc          = resume_pc;
			res.saved_status      = status_word;
			res.new_status        = status_word & (WordW'(1) << Scg0Bit);
			res.left_low_power    = |status_word[LpmHi:LpmLo];
			res.clear_source_flag = clr_flag;
			pending_nxt[top_irq]  = 1'b0;
		end
		res.pending_after = WordW'(pending_nxt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_acc) begin
			pending_q <= pending_nxt;
		end
	end

	// result register and skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= in_acc;
			end
		end else if (in_acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_acc) begin
				out_q <= res;
			end
		end else if (in_acc) begin
			skid_q <= res;
		end
	end

	assign out_valid         = out_valid_q;
	assign taken             = out_q.taken;
	assign served_irq        = out_q.served_irq;
	assign vector_address    = out_q.vector_address;
	assign new_stack_pointer = out_q.new_stack_pointer;
	assign saved_pc          = out_q.saved_pc;
	assign saved_status      = out_q.saved_status;
	assign new_status        = out_q.new_status;
	assign left_low_power    = out_q.left_low_power;
	assign clear_source_flag = out_q.clear_source_flag;
	assign masked_warning    = out_q.masked_warning;
	assign pending_after     = out_q.pending_after;

`ifndef SYNTHESIS
	// skid entry is only ever filled behind a held result
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without a result in the output register");

	// a served vector never remains pending
	a_served_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.taken) |-> !out_q.pending_after[out_q.served_irq])
		else $error("served vector still pending");

	// warnings come only from raise beats, never together with an acceptance
	a_warn_not_taken: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.masked_warning && out_q.taken))
		else $error("masked warning on an accepted interrupt");

	// pending register moves only on an accepted beat
	a_pending_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(pending_q))
		else $error("pending register changed without an input beat");
`endif

endmodule : priority_interrupt_acceptor_core
`default_nettype wire
